>>> rtl/lbct_pkg.sv
package lbct_pkg;

    // Operation codes of the operation field
    localparam logic OP_TEST  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Fixed result field widths
    localparam int HIT_W  = 8;
    localparam int HELD_W = 9;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

>>> rtl/lbct_ram.sv
module lbct_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lbct_lane.sv
// One projection lane: dot product of a point with the current axis.
module lbct_lane #(
    parameter int COORD_BITS = 20
) (
    input  logic                           clk,
    input  logic signed [COORD_BITS:0]     axis_x,
    input  logic signed [COORD_BITS:0]     axis_y,
    input  logic signed [COORD_BITS-1:0]   pt_x,
    input  logic signed [COORD_BITS-1:0]   pt_y,
    output logic signed [2*COORD_BITS+1:0] dot_reg
);

    localparam int PW = 2 * COORD_BITS + 1;

    logic signed [PW-1:0] prod_x_reg;
    logic signed [PW-1:0] prod_y_reg;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= axis_x * pt_x;
        prod_y_reg <= axis_y * pt_y;
        dot_reg    <= {prod_x_reg[PW-1], prod_x_reg} + {prod_y_reg[PW-1], prod_y_reg};
    end

endmodule

>>> rtl/lbct_merge.sv
// Combines the lane projections: extents of both quads, separation flag.
module lbct_merge #(
    parameter int CORNERS    = 4,
    parameter int COORD_BITS = 20
) (
    input  logic                           clk,
    input  logic signed [2*COORD_BITS+1:0] dot [2*CORNERS],
    output logic                           sep_reg
);

    localparam int SW = 2 * COORD_BITS + 2;

    logic signed [SW-1:0] amin;
    logic signed [SW-1:0] amax;
    logic signed [SW-1:0] bmin;
    logic signed [SW-1:0] bmax;

    always_comb
    begin
        amin = dot[0];
        amax = dot[0];
        bmin = dot[CORNERS];
        bmax = dot[CORNERS];
        for (int k = 1; k < CORNERS; k++)
        begin
            if (dot[k] < amin) amin = dot[k];
            if (dot[k] > amax) amax = dot[k];
            if (dot[CORNERS+k] < bmin) bmin = dot[CORNERS+k];
            if (dot[CORNERS+k] > bmax) bmax = dot[CORNERS+k];
        end
    end

    // touching extents do not separate
    always_ff @(posedge clk)
    begin
        sep_reg <= (amax < bmin) || (bmax < amin);
    end

endmodule

>>> rtl/label_box_collision_table.sv
// Timing: a clear strobes its result in the cycle after start; a test first enters the
//   scan state, which ends at once against an empty table, else once the axes of the
//   stored quads have passed the pipe; an overlap at entry h ends the scan at entry h.
// Throughput: one separating axis per cycle, set by the shared lane set and the one
//   table row read per cycle; one transaction at a time (busy while scanning).
// Reset clears the entry count; table contents stay undefined. Receiver cannot stall.
module label_box_collision_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int CORNERS     = 4,
    parameter int COORD_BITS  = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic signed [COORD_BITS-1:0] corner0_x,
    input  logic signed [COORD_BITS-1:0] corner0_y,
    input  logic signed [COORD_BITS-1:0] corner1_x,
    input  logic signed [COORD_BITS-1:0] corner1_y,
    input  logic signed [COORD_BITS-1:0] corner2_x,
    input  logic signed [COORD_BITS-1:0] corner2_y,
    input  logic signed [COORD_BITS-1:0] corner3_x,
    input  logic signed [COORD_BITS-1:0] corner3_y,
    output logic                         done,
    output logic                         overlap,
    output logic                         inserted,
    output logic                         table_full,
    output logic [lbct_pkg::HIT_W-1:0]   hit_index,
    output logic [lbct_pkg::HELD_W-1:0]  entries_held
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int NA   = 2 * CORNERS;              // axes per stored entry
    localparam int AIW  = $clog2(NA);
    localparam int CB   = COORD_BITS;
    localparam int RW   = 2 * CORNERS * CB;         // one table row: a whole quad
    localparam int SW   = 2 * CB + 2;
    localparam int PIPE = 5;

    // tag that travels with each axis down the pipe
    typedef struct packed {
        logic           valid;
        logic [IW-1:0]  entry;
        logic [AIW-1:0] axis;
    } meta_t;

    lbct_pkg::state_t state_reg, state_next;

    logic [RW-1:0]     cand_reg, cand_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     iss_e_reg, iss_e_next;
    logic [AIW-1:0]    iss_a_reg, iss_a_next;
    logic              iss_on_reg, iss_on_next;
    logic              sep_acc_reg, sep_acc_next;
    meta_t             meta_reg [PIPE];
    logic              flush;

    logic              done_reg, done_next;
    logic              overlap_reg, overlap_next;
    logic              inserted_reg, inserted_next;
    logic              full_reg, full_next;
    logic [lbct_pkg::HIT_W-1:0]  hit_reg, hit_next;
    logic [lbct_pkg::HELD_W-1:0] held_reg, held_next;

    logic              ram_we;
    logic [RW-1:0]     row;

    // ---------------------------------------------------------------
    // Candidate quad: corners past the fourth repeat the fourth
    // ---------------------------------------------------------------
    logic signed [CB-1:0] in_x [4];
    logic signed [CB-1:0] in_y [4];
    logic [RW-1:0]        in_quad;

    assign in_x[0] = corner0_x;
    assign in_y[0] = corner0_y;
    assign in_x[1] = corner1_x;
    assign in_y[1] = corner1_y;
    assign in_x[2] = corner2_x;
    assign in_y[2] = corner2_y;
    assign in_x[3] = corner3_x;
    assign in_y[3] = corner3_y;

    for (genvar k = 0; k < CORNERS; k++)
    begin : g_pack
        localparam int SRC = (k < 4) ? k : 3;
        assign in_quad[(2*k)*CB +: CB]   = in_x[SRC];
        assign in_quad[(2*k+1)*CB +: CB] = in_y[SRC];
    end

    // ---------------------------------------------------------------
    // Table memory, one quad per row
    // ---------------------------------------------------------------
    lbct_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(count_reg)),
        .wdata (cand_reg),
        .raddr (iss_e_reg),
        .rdata (row)
    );

    // ---------------------------------------------------------------
    // Axis stage: points 0..C-1 are the candidate, C..2C-1 the stored quad.
    // All edges are formed at once, the axis of this cycle is picked.
    // ---------------------------------------------------------------
    logic signed [CB-1:0] pts_x [NA];
    logic signed [CB-1:0] pts_y [NA];
    logic signed [CB:0]   edge_x [NA];
    logic signed [CB:0]   edge_y [NA];

    for (genvar j = 0; j < NA; j++)
    begin : g_edge
        localparam int BASE = (j < CORNERS) ? 0 : CORNERS;
        localparam int KK   = j - BASE;
        localparam int PREV = BASE + ((KK == 0) ? CORNERS - 1 : KK - 1);
        if (j < CORNERS)
        begin : g_cand
            assign pts_x[j] = cand_reg[(2*KK)*CB +: CB];
            assign pts_y[j] = cand_reg[(2*KK+1)*CB +: CB];
        end
        else
        begin : g_stor
            assign pts_x[j] = row[(2*KK)*CB +: CB];
            assign pts_y[j] = row[(2*KK+1)*CB +: CB];
        end
        assign edge_x[j] = {pts_x[j][CB-1], pts_x[j]} - {pts_x[PREV][CB-1], pts_x[PREV]};
        assign edge_y[j] = {pts_y[j][CB-1], pts_y[j]} - {pts_y[PREV][CB-1], pts_y[PREV]};
    end

    logic signed [CB:0]   axis_x_reg;
    logic signed [CB:0]   axis_y_reg;
    logic signed [CB-1:0] pt_x_reg [NA];
    logic signed [CB-1:0] pt_y_reg [NA];

    // axis = (edge.y, -edge.x)
    always_ff @(posedge clk)
    begin
        axis_x_reg <= edge_y[meta_reg[0].axis];
        axis_y_reg <= -edge_x[meta_reg[0].axis];
        for (int j = 0; j < NA; j++)
        begin
            pt_x_reg[j] <= pts_x[j];
            pt_y_reg[j] <= pts_y[j];
        end
    end

    // ---------------------------------------------------------------
    // Projection lanes, one per corner of both quads, then the merge
    // ---------------------------------------------------------------
    logic signed [SW-1:0] dot [NA];
    logic                 sep_reg;

    for (genvar j = 0; j < NA; j++)
    begin : g_lane
        lbct_lane #(
            .COORD_BITS (CB)
        ) u_lane (
            .clk     (clk),
            .axis_x  (axis_x_reg),
            .axis_y  (axis_y_reg),
            .pt_x    (pt_x_reg[j]),
            .pt_y    (pt_y_reg[j]),
            .dot_reg (dot[j])
        );
    end

    lbct_merge #(
        .CORNERS    (CORNERS),
        .COORD_BITS (CB)
    ) u_merge (
        .clk     (clk),
        .dot     (dot),
        .sep_reg (sep_reg)
    );

    // ---------------------------------------------------------------
    // Control: issue, per-entry decision, insert
    // ---------------------------------------------------------------
    meta_t tail;
    logic  entry_end;
    logic  sep_any;
    logic  last_entry;

    assign tail       = meta_reg[PIPE-1];
    assign entry_end  = tail.valid && (tail.axis == AIW'(NA - 1));
    assign sep_any    = sep_acc_reg | sep_reg;
    assign last_entry = (CW'(tail.entry) + CW'(1)) == count_reg;

    always_comb
    begin
        state_next    = state_reg;
        cand_next     = cand_reg;
        count_next    = count_reg;
        iss_e_next    = iss_e_reg;
        iss_a_next    = iss_a_reg;
        iss_on_next   = iss_on_reg;
        sep_acc_next  = sep_acc_reg;
        done_next     = 1'b0;
        overlap_next  = overlap_reg;
        inserted_next = inserted_reg;
        full_next     = full_reg;
        hit_next      = hit_reg;
        held_next     = held_reg;
        ram_we        = 1'b0;
        flush         = 1'b0;

        unique case (state_reg)
            lbct_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == lbct_pkg::OP_CLEAR)
                    begin
                        count_next    = '0;
                        done_next     = 1'b1;
                        overlap_next  = 1'b0;
                        inserted_next = 1'b0;
                        full_next     = 1'b0;
                        hit_next      = '0;
                        held_next     = '0;
                    end
                    else
                    begin
                        cand_next   = in_quad;
                        iss_e_next  = '0;
                        iss_a_next  = '0;
                        iss_on_next = (count_reg != '0);
                        state_next  = lbct_pkg::ST_SCAN;
                    end
                end
            end

            lbct_pkg::ST_SCAN:
            begin
                // issue one axis per cycle, entry by entry
                if (iss_on_reg)
                begin
                    if (iss_a_reg == AIW'(NA - 1))
                    begin
                        iss_a_next = '0;
                        if ((CW'(iss_e_reg) + CW'(1)) == count_reg)
                        begin
                            iss_on_next = 1'b0;
                        end
                        else
                        begin
                            iss_e_next = iss_e_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        iss_a_next = iss_a_reg + AIW'(1);
                    end
                end

                if (tail.valid)
                begin
                    sep_acc_next = entry_end ? 1'b0 : sep_any;
                end

                if ((count_reg == '0) || (entry_end && (!sep_any || last_entry)))
                begin
                    done_next     = 1'b1;
                    flush         = 1'b1;
                    iss_on_next   = 1'b0;
                    sep_acc_next  = 1'b0;
                    state_next    = lbct_pkg::ST_IDLE;
                    inserted_next = 1'b0;
                    full_next     = 1'b0;
                    if ((count_reg != '0) && !sep_any)
                    begin
                        overlap_next = 1'b1;
                        hit_next     = lbct_pkg::HIT_W'(tail.entry);
                        held_next    = lbct_pkg::HELD_W'(count_reg);
                    end
                    else
                    begin
                        overlap_next = 1'b0;
                        hit_next     = '0;
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            ram_we        = 1'b1;
                            count_next    = count_reg + CW'(1);
                            inserted_next = 1'b1;
                            held_next     = lbct_pkg::HELD_W'(count_reg + CW'(1));
                        end
                        else
                        begin
                            full_next = 1'b1;
                            held_next = lbct_pkg::HELD_W'(count_reg);
                        end
                    end
                end
            end

            default:
            begin
                state_next = lbct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lbct_pkg::ST_IDLE;
            count_reg   <= '0;
            iss_on_reg  <= 1'b0;
            sep_acc_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int p = 0; p < PIPE; p++)
            begin
                meta_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_on_reg  <= iss_on_next;
            sep_acc_reg <= sep_acc_next;
            done_reg    <= done_next;
            // later axes still in flight are dropped once the answer is known
            meta_reg[0].valid <= iss_on_reg && !flush;
            meta_reg[0].entry <= iss_e_reg;
            meta_reg[0].axis  <= iss_a_reg;
            for (int p = 1; p < PIPE; p++)
            begin
                meta_reg[p].valid <= meta_reg[p-1].valid && !flush;
                meta_reg[p].entry <= meta_reg[p-1].entry;
                meta_reg[p].axis  <= meta_reg[p-1].axis;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        iss_e_reg    <= iss_e_next;
        iss_a_reg    <= iss_a_next;
        overlap_reg  <= overlap_next;
        inserted_reg <= inserted_next;
        full_reg     <= full_next;
        hit_reg      <= hit_next;
        held_reg     <= held_next;
    end

    assign busy         = (state_reg != lbct_pkg::ST_IDLE);
    assign done         = done_reg;
    assign overlap      = overlap_reg;
    assign inserted     = inserted_reg;
    assign table_full   = full_reg;
    assign hit_index    = hit_reg;
    assign entries_held = held_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({overlap, inserted, table_full}) <= 1)
        else $error("more than one outcome flag set");

    a_start_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction produced neither scan nor result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && inserted) |-> (count_reg != '0) && ($past(count_reg) + CW'(1) == count_reg))
        else $error("insert did not advance the entry count");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !iss_on_reg)
        else $error("axis issue active while idle");

endmodule

>>> verif/label_box_collision_table_tb.sv
`timescale 1ns / 100ps

module label_box_collision_table_tb;

    localparam int COORD_W    = 20;
    localparam int DEPTH      = 256;
    localparam int STALL_MAX  = 20000; // longest scan covers every axis of a full table, plus sender gaps
    localparam int CELL       = 65536; // grid cell for non-overlapping fill, 16x16 cells
    localparam logic signed [COORD_W-1:0] CMIN = COORD_W'(-(1 <<< (COORD_W-1)));
    localparam logic signed [COORD_W-1:0] CMAX = COORD_W'((1 <<< (COORD_W-1)) - 1);

    // one command transaction: operation plus four corners as x0,y0,x1,y1,...
    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] c [8];
    } quad_txn_t;

    typedef struct {
        logic                          overlap;
        logic                          inserted;
        logic                          table_full;
        logic [lbct_pkg::HIT_W-1:0]    hit_index;
        logic [lbct_pkg::HELD_W-1:0]   entries_held;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic operation = lbct_pkg::OP_TEST;
    logic signed [COORD_W-1:0] corner0_x = '0, corner0_y = '0, corner1_x = '0, corner1_y = '0;
    logic signed [COORD_W-1:0] corner2_x = '0, corner2_y = '0, corner3_x = '0, corner3_y = '0;
    logic busy, done, overlap, inserted, table_full;
    logic [lbct_pkg::HIT_W-1:0]  hit_index;
    logic [lbct_pkg::HELD_W-1:0] entries_held;

    label_box_collision_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operation(operation),
        .corner0_x(corner0_x), .corner0_y(corner0_y), .corner1_x(corner1_x),
        .corner1_y(corner1_y), .corner2_x(corner2_x), .corner2_y(corner2_y),
        .corner3_x(corner3_x), .corner3_y(corner3_y),
        .done(done), .overlap(overlap), .inserted(inserted), .table_full(table_full),
        .hit_index(hit_index), .entries_held(entries_held)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    quad_txn_t  pending_quads [$];
    placement_t expected_placements [$];
    int         error_count = 0;

    // shadow of the label table kept by the predictor
    longint shadow_quads [DEPTH][8];
    int     shadow_count = 0;

    task automatic report_mismatch(input string msg);
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // --------------------------------------------------------------------
    // Separating axis predictor. Products are at most ~2^41, so longint is
    // exact and needs no widening.
    // --------------------------------------------------------------------
    function automatic void project_extent(input longint q[8], input longint ax,
                                           input longint ay, output longint mn,
                                           output longint mx);
        longint d;
        begin
            for (int k = 0; k < 4; k++)
            begin
                d = ax * q[2*k] + ay * q[2*k+1];
                if (k == 0 || d < mn) mn = d;
                if (k == 0 || d > mx) mx = d;
            end
        end
    endfunction

    // true if some edge normal of a splits a from b
    function automatic bit edge_axis_splits(input longint a[8], input longint b[8]);
        longint ex, ey, amin, amax, bmin, bmax;
        int prev;
        begin
            prev = 3;
            for (int k = 0; k < 4; k++)
            begin
                ex = a[2*k] - a[2*prev];
                ey = a[2*k+1] - a[2*prev+1];
                project_extent(a, ey, -ex, amin, amax);
                project_extent(b, ey, -ex, bmin, bmax);
                // touching extents are not a split
                if (amax < bmin || bmax < amin) return 1'b1;
                prev = k;
            end
            return 1'b0;
        end
    endfunction

    function automatic placement_t place_label(input quad_txn_t t);
        placement_t r;
        longint q[8];
        begin
            r = '{default: '0};
            if (t.op == lbct_pkg::OP_CLEAR)
            begin
                shadow_count = 0;
                return r;
            end
            for (int k = 0; k < 8; k++) q[k] = t.c[k];
            for (int i = 0; i < shadow_count; i++)
            begin
                if (!edge_axis_splits(q, shadow_quads[i]) && !edge_axis_splits(shadow_quads[i], q))
                begin
                    r.overlap   = 1'b1;
                    r.hit_index = i[lbct_pkg::HIT_W-1:0];
                    break;
                end
            end
            if (!r.overlap)
            begin
                if (shadow_count < DEPTH)
                begin
                    shadow_quads[shadow_count] = q;
                    shadow_count++;
                    r.inserted = 1'b1;
                end
                else
                    r.table_full = 1'b1;
            end
            r.entries_held = shadow_count[lbct_pkg::HELD_W-1:0];
            return r;
        end
    endfunction

    // --------------------------------------------------------------------
    // Stimulus builders
    // --------------------------------------------------------------------
    function automatic void queue_quad(input logic op, input int x0, input int y0,
                                       input int x1, input int y1, input int x2,
                                       input int y2, input int x3, input int y3);
        quad_txn_t t;
        begin
            t.op = op;
            t.c[0] = COORD_W'(x0); t.c[1] = COORD_W'(y0);
            t.c[2] = COORD_W'(x1); t.c[3] = COORD_W'(y1);
            t.c[4] = COORD_W'(x2); t.c[5] = COORD_W'(y2);
            t.c[6] = COORD_W'(x3); t.c[7] = COORD_W'(y3);
            pending_quads = {pending_quads, t};
        end
    endfunction

    function automatic void queue_rect(input int xl, input int yl, input int xh, input int yh,
                                       input bit cw);
        begin
            if (cw) queue_quad(lbct_pkg::OP_TEST, xl, yl, xl, yh, xh, yh, xh, yl);
            else    queue_quad(lbct_pkg::OP_TEST, xl, yl, xh, yl, xh, yh, xl, yh);
        end
    endfunction

    // random full-range corners, any shape
    function automatic void queue_noise(input logic op);
        quad_txn_t t;
        begin
            t.op = op;
            for (int k = 0; k < 8; k++) t.c[k] = COORD_W'($urandom);
            pending_quads = {pending_quads, t};
        end
    endfunction

    // random convex rectangle strictly inside grid cell n, so cells never touch
    function automatic void queue_cell_rect(input int n);
        int ox, oy, xl, xh, yl, yh;
        begin
            ox = -524288 + (n % 16) * CELL;
            oy = -524288 + ((n / 16) % 16) * CELL;
            xl = ox + $urandom_range(1, CELL/2 - 1);
            xh = ox + $urandom_range(CELL/2, CELL - 2);
            yl = oy + $urandom_range(1, CELL/2 - 1);
            yh = oy + $urandom_range(CELL/2, CELL - 2);
            queue_rect(xl, yl, xh, yh, $urandom_range(0, 1));
        end
    endfunction

    // --------------------------------------------------------------------
    // Driver: inputs change on the falling edge; taken marks acceptance
    // --------------------------------------------------------------------
    logic taken = 1'b0;
    int   gap_left = 0;

    always @(negedge clk)
    begin
        quad_txn_t t;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken)
            ; // hold until the block takes the transaction
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (pending_quads.size() > 0)
        begin
            t = pending_quads.pop_front();
            operation <= t.op;
            corner0_x <= t.c[0]; corner0_y <= t.c[1];
            corner1_x <= t.c[2]; corner1_y <= t.c[3];
            corner2_x <= t.c[4]; corner2_y <= t.c[5];
            corner3_x <= t.c[6]; corner3_y <= t.c[7];
            start <= 1'b1;
            // mostly back to back or short gaps, now and then a long one
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap_left <= 0;
                4, 5, 6, 7: gap_left <= $urandom_range(1, 3);
                default:    gap_left <= $urandom_range(4, 30);
            endcase
        end
        else
            start <= 1'b0;
    end

    // --------------------------------------------------------------------
    // Monitor: accepts on the rising edge, predicts and checks
    // --------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        quad_txn_t  t;
        placement_t e;
        if (rst_n)
        begin
            taken <= start && !busy;
            if (start && !busy)
            begin
                t.op = operation;
                t.c[0] = corner0_x; t.c[1] = corner0_y; t.c[2] = corner1_x; t.c[3] = corner1_y;
                t.c[4] = corner2_x; t.c[5] = corner2_y; t.c[6] = corner3_x; t.c[7] = corner3_y;
                expected_placements = {expected_placements, place_label(t)};
            end
            if (done)
            begin
                if (expected_placements.size() == 0)
                    report_mismatch("result strobe with no transaction outstanding");
                else
                begin
                    e = expected_placements.pop_front();
                    if (overlap !== e.overlap)
                        report_mismatch($sformatf("overlap %b, want %b", overlap, e.overlap));
                    if (inserted !== e.inserted)
                        report_mismatch($sformatf("inserted %b, want %b", inserted, e.inserted));
                    if (table_full !== e.table_full)
                        report_mismatch($sformatf("table_full %b, want %b",
                                                  table_full, e.table_full));
                    if (hit_index !== e.hit_index)
                        report_mismatch($sformatf("hit_index %0d, want %0d",
                                                  hit_index, e.hit_index));
                    if (entries_held !== e.entries_held)
                        report_mismatch($sformatf("entries_held %0d, want %0d",
                                                  entries_held, e.entries_held));
                end
            end
            idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: nothing moving for far longer than the slowest scan
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_MAX)
        begin
            $display("label_box_collision_table regression: fail");
            $finish;
        end
    end

    initial
    begin
        int used_cells;

        // directed: clear, degenerate point, touching, extremes, winding, non-convex
        queue_noise(lbct_pkg::OP_CLEAR);
        queue_quad(lbct_pkg::OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0);   // point quad, zero axes
        queue_quad(lbct_pkg::OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0);   // same point overlaps entry 0
        queue_rect(16, 16, 160, 160, 0);
        queue_rect(160, 16, 320, 160, 1);                    // shares an edge: touching
        queue_rect(161, 16, 320, 160, 0);                    // one lsb clear: inserted
        queue_quad(lbct_pkg::OP_TEST, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX);
        queue_quad(lbct_pkg::OP_TEST, -9000, -9000, -8000, -8900, -8990, -8990,
                   -8900, -8000);                            // non-convex
        queue_quad(lbct_pkg::OP_TEST, 5000, 5000, 6000, 6000, 7000, 7000,
                   8000, 8000);                              // collinear
        queue_quad(lbct_pkg::OP_CLEAR, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_quad(lbct_pkg::OP_TEST, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN);
        queue_quad(lbct_pkg::OP_TEST, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        queue_quad(lbct_pkg::OP_TEST, -1, -1, -1, -1, -1, -1, -1, -1);
        queue_quad(lbct_pkg::OP_CLEAR, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        queue_quad(lbct_pkg::OP_TEST, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_quad(lbct_pkg::OP_TEST, CMAX-1, CMAX-1, CMAX-1, CMAX-1, CMAX-1, CMAX-1,
                   CMAX-1, CMAX-1);
        queue_quad(lbct_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);

        // random noise, then a fill of the table with disjoint cells plus overlap probes
        for (int i = 0; i < 15; i++)
            queue_noise($urandom_range(0, 7) == 0 ? lbct_pkg::OP_CLEAR : lbct_pkg::OP_TEST);
        queue_noise(lbct_pkg::OP_CLEAR);
        used_cells = 0;
        for (int i = 0; i < 258; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1:    if (used_cells > 0) queue_cell_rect($urandom_range(0, used_cells - 1));
                         else queue_noise(lbct_pkg::OP_TEST);
                2:       queue_noise(lbct_pkg::OP_TEST);
                default: begin
                    queue_cell_rect(used_cells % 256);
                    used_cells++;
                end
            endcase
        end
        // table should be full or nearly so: probes past the end
        for (int i = 0; i < 4; i++) queue_cell_rect($urandom_range(0, 255));
        queue_noise(lbct_pkg::OP_CLEAR);
        queue_cell_rect(0);

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (pending_quads.size() == 0 && !start && expected_placements.size() == 0);
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_placements.size() == 0)
            $display("label_box_collision_table regression: pass");
        else
            $display("label_box_collision_table regression: fail");
        $finish;
    end

endmodule
